/* hw/rtl/assert_macros.svh */
// Assertion helpers used by binary_to_decimal_ascii.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must be false at every clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// Whenever the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

/* hw/rtl/bda_pkg.sv */
package bda_pkg;

  localparam int VALUE_W = 16;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;
  localparam int PROG_LEN = 10;
  localparam int PC_W    = $clog2(PROG_LEN);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_SUB,
    OP_EMIT,
    OP_UNITS
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IDLE,
    COND_GE
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      wsel;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic logic [VALUE_W-1:0] place_weight(input logic [1:0] wsel);
    logic [VALUE_W-1:0] w;
    case (wsel)
      2'd0: w = 16'd10000;
      2'd1: w = 16'd1000;
      2'd2: w = 16'd100;
      default: w = 16'd10;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/bda_sequencer.sv */
module bda_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            ge,
  output bda_pkg::ctrl_t  ctrl,
  output logic            busy
);
  import bda_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            taken;

  // Program: wait, then a subtract loop and an emit step for each of the
  // four places, then the units digit and back to the wait step.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      4'd0: w = '{op: OP_WAIT,  wsel: 2'd0, cond: COND_IDLE,   target: 4'd0};
      4'd1: w = '{op: OP_SUB,   wsel: 2'd0, cond: COND_GE,     target: 4'd1};
      4'd2: w = '{op: OP_EMIT,  wsel: 2'd0, cond: COND_NEVER,  target: 4'd0};
      4'd3: w = '{op: OP_SUB,   wsel: 2'd1, cond: COND_GE,     target: 4'd3};
      4'd4: w = '{op: OP_EMIT,  wsel: 2'd1, cond: COND_NEVER,  target: 4'd0};
      4'd5: w = '{op: OP_SUB,   wsel: 2'd2, cond: COND_GE,     target: 4'd5};
      4'd6: w = '{op: OP_EMIT,  wsel: 2'd2, cond: COND_NEVER,  target: 4'd0};
      4'd7: w = '{op: OP_SUB,   wsel: 2'd3, cond: COND_GE,     target: 4'd7};
      4'd8: w = '{op: OP_EMIT,  wsel: 2'd3, cond: COND_NEVER,  target: 4'd0};
      4'd9: w = '{op: OP_UNITS, wsel: 2'd3, cond: COND_ALWAYS, target: 4'd0};
      default: w = '{op: OP_WAIT, wsel: 2'd0, cond: COND_ALWAYS, target: 4'd0};
    endcase
    return w;
  endfunction

  assign ctrl = ucode(pc);
  assign busy = (pc != '0);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:  taken = 1'b0;
      COND_ALWAYS: taken = 1'b1;
      COND_IDLE:   taken = !start;
      COND_GE:     taken = ge;
      default:     taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hw/rtl/bda_datapath.sv */
module bda_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bda_pkg::ctrl_t                ctrl,
  input  logic                          start,
  input  logic [bda_pkg::VALUE_W-1:0]   value,
  output logic                          ge,
  output logic [bda_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last,
  output logic                          char_valid
);
  import bda_pkg::*;

  logic [VALUE_W-1:0] rest;
  logic [VALUE_W-1:0] weight;
  logic [DIGIT_W-1:0] digit;
  logic               started;

  assign weight = place_weight(ctrl.wsel);
  assign ge     = (rest >= weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      last       <= 1'b0;
      started    <= 1'b0;
    end else begin
      char_valid <= 1'b0;
      last       <= 1'b0;
      case (ctrl.op)
        OP_WAIT: begin
          if (start) begin
            rest    <= value;
            digit   <= '0;
            started <= 1'b0;
          end
        end
        OP_SUB: begin
          if (ge) begin
            rest  <= rest - weight;
            digit <= digit + DIGIT_W'(1);
          end
        end
        OP_EMIT: begin
          // Leading zeros stay silent until the first nonzero digit.
          if (started || digit != '0) begin
            char_valid <= 1'b1;
            digit_char <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            started    <= 1'b1;
          end
          digit <= '0;
        end
        OP_UNITS: begin
          char_valid <= 1'b1;
          last       <= 1'b1;
          digit_char <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, rest[DIGIT_W-1:0]};
        end
        default: begin
          digit <= '0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/binary_to_decimal_ascii.sv */
// Unsigned 16-bit binary to ASCII decimal text, most significant digit first.
// Input: drive value and raise start; the transaction is taken at the clock
// edge where start is high and busy is low. busy stays high until the units
// digit has been issued.
// Output: each character appears on digit_char for one cycle with char_valid
// high; last marks the units digit, which always closes the number. Leading
// zeros are dropped, so zero gives the single character '0'.
// Timing: a microcoded sequencer steps through one control word per cycle.
// In each of the four places a subtract step repeats while the weight fits
// and runs once more when it no longer does, then an emit step follows; the
// units step closes the number. No new number is taken while busy is high,
// and the next transaction is taken on the cycle the last character is shown.
// Reset (rst, synchronous) returns the sequencer to its wait step and
// drops char_valid. The receiver cannot stall; every character must be
// taken in the cycle it is shown.
`include "assert_macros.svh"

module binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bda_pkg::VALUE_W-1:0]   value,
  output logic [bda_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last,
  output logic                          char_valid
);
  import bda_pkg::*;

  ctrl_t ctrl;
  logic  ge;

  bda_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ge    (ge),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  bda_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .start      (start),
    .value      (value),
    .ge         (ge),
    .digit_char (digit_char),
    .last       (last),
    .char_valid (char_valid)
  );

  `ASSERT_IMPLIES(a_last_is_valid, clk, rst, last, char_valid)
  `ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLIES(a_last_frees_block, clk, rst, char_valid && last, !busy)
  `ASSERT_NEVER(a_char_while_idle, clk, rst, char_valid && !last && !busy)

endmodule

/* verif/testbench.sv */
module testbench;
  import bda_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } text_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [VALUE_W-1:0]  value = '0;
  logic                busy;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;
  logic                char_valid;

  text_char_t expected_chars[$];
  int unsigned error_count = 0;
  int unsigned numbers_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned cycle_count = 0;

  binary_to_decimal_ascii uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .digit_char (digit_char),
    .last       (last),
    .char_valid (char_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Expected text of one number: digits found by repeated subtraction,
  // with leading zeros dropped and the units digit always present.
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] number);
    int unsigned weights[4] = '{10000, 1000, 100, 10};
    int unsigned rest;
    int unsigned digit;
    bit leading;
    text_char_t ch;
    rest = 32'(number);
    leading = 1'b1;
    foreach (weights[p]) begin
      digit = 0;
      while (rest >= weights[p]) begin
        rest -= weights[p];
        digit++;
      end
      if (!leading || digit != 0) begin
        ch.digit_char = CHAR_ZERO + digit[CHAR_W-1:0];
        ch.last = 1'b0;
        expected_chars.push_back(ch);
        leading = 1'b0;
      end
    end
    ch.digit_char = CHAR_ZERO + rest[CHAR_W-1:0];
    ch.last = 1'b1;
    expected_chars.push_back(ch);
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && char_valid) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got char %0d last %0b",
                 $time, digit_char, last);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (digit_char !== want.digit_char) begin
          $display("%0t: digit_char mismatch, expected %0d, got %0d",
                   $time, want.digit_char, digit_char);
          error_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, last);
          error_count++;
        end
      end
    end
  end

  // Each cycle before start is raised, the sender idles with the given
  // chance. Start is left high after a transaction, so numbers can follow
  // one another without a dead cycle.
  task automatic send_number(input logic [VALUE_W-1:0] number, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      value <= VALUE_W'($urandom_range(0, 65535));
      @(negedge clk);
    end
    start <= 1'b1;
    value <= number;
    do @(posedge clk); while (busy);
    predict_decimal_text(number);
    numbers_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] random_number();
    logic [VALUE_W-1:0] n;
    case ($urandom_range(0, 6))
      0: n = VALUE_W'($urandom_range(0, 9));
      1: n = VALUE_W'($urandom_range(10, 99));
      2: n = VALUE_W'($urandom_range(100, 999));
      3: n = VALUE_W'($urandom_range(1000, 9999));
      4: n = VALUE_W'($urandom_range(10000, 65535));
      // Numbers with zero digits in the middle, e.g. 50307.
      5: n = VALUE_W'($urandom_range(1, 6) * 10000 + $urandom_range(0, 1) * 1000
             + $urandom_range(0, 9) * 100 * $urandom_range(0, 1) + $urandom_range(0, 9));
      default: n = VALUE_W'($urandom_range(0, 65535));
    endcase
    return n;
  endfunction

  task automatic test_directed_values();
    logic [VALUE_W-1:0] corner[$] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100,
                                      16'd999, 16'd1000, 16'd9999, 16'd10000,
                                      16'd10001, 16'd10010, 16'd50000, 16'd59999,
                                      16'd60000, 16'd65534, 16'd65535, 16'h5555,
                                      16'hAAAA, 16'h8000, 16'd7, 16'd40302};
    foreach (corner[i]) send_number(corner[i], 30);
  endtask

  task automatic run_random_numbers(input int count, input int idle_pct);
    repeat (count) send_number(random_number(), idle_pct);
  endtask

  task automatic test_sparse_sender_gaps();
    run_random_numbers(63, 18);
  endtask

  task automatic test_frequent_sender_gaps();
    run_random_numbers(63, 78);
  endtask

  task automatic test_back_to_back_numbers();
    run_random_numbers(63, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_values();
    test_sparse_sender_gaps();
    test_frequent_sender_gaps();
    test_back_to_back_numbers();

    @(negedge clk);
    start <= 1'b0;
    while (expected_chars.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d numbers (corner values, then random with light, heavy and no gaps),",
             numbers_sent);
    $display("checking %0d characters with %0d errors.", chars_checked, error_count);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bda_pkg.sv
hw/rtl/bda_sequencer.sv
hw/rtl/bda_datapath.sv
hw/rtl/binary_to_decimal_ascii.sv
verif/testbench.sv
